FILE: rtl/core/text_console_writer_assert.svh
// assertion macros shared by the text console writer modules
// the including module must have clk and rst_n in scope
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// property checked on every clock edge outside reset
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// same-cycle implication checked outside reset
`define TCW_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tcw_pkg.sv
// shared types and constants of the text console writer
// screen geometry, request and result structs, controller/datapath interface
package tcw_pkg;

  localparam int COLS         = 80;
  localparam int ROWS         = 25;
  localparam int TAB_STOP     = 8;
  localparam int CELLS        = ROWS * COLS;
  localparam int SCROLL_CELLS = (ROWS - 1) * COLS;

  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int IDX_W   = 11;
  localparam int CELL_W  = 16;
  localparam int COLOR_W = 4;
  localparam int CHAR_W  = 8;
  localparam int OP_W    = 2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_LINE  = 2'd2;
  localparam logic [OP_W-1:0] OP_READ  = 2'd3;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } in_req_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [IDX_W-1:0]  cursor_index;
    logic [CELL_W-1:0] read_cell;
  } out_rsp_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic scroll_step;
    logic fill_step;
    logic load_out;
  } tcw_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic scroll;
    logic copy_done;
    logic fill_last;
    logic out_busy;
  } tcw_sts_t;

endpackage

FILE: rtl/core/text_console_writer.sv
// text console writer: 80x25 screen store with cursor, colours and scrolling
// a request is loaded, executed, and its result then loaded into the result register
// a clear blanks the whole store, one cell a cycle; a scroll copies rows 1 to 24 up
// a row, then blanks row 24; a request waits for idle, but the result register lets
// a new request in while a result waits. synchronous reset clears cursor to 0,0 and
// colours to fg 15 bg 0; screen contents are undefined until cleared or written
module text_console_writer import tcw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_req_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_rsp_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_wdata
);

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_data  (out_data),
    .out_valid (out_valid),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

FILE: rtl/core/tcw_datapath.sv
// datapath of the text console writer: cursor, colours, screen store, result register
// depends on tcw_pkg and the assertion macro header
`include "text_console_writer_assert.svh"

module tcw_datapath import tcw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_req_t              in_data,
  input  logic                 out_ready,
  output out_rsp_t             out_data,
  output logic                 out_valid,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_wdata,
  input  tcw_cmd_t             cmd,
  output tcw_sts_t             sts
);

  logic [CELL_W-1:0] mem [0:CELLS-1];
  logic [CELL_W-1:0] mem_q;

  in_req_t             item_r;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [COLOR_W-1:0]  fg_r, bg_r;
  logic [IDX_W-1:0]    sweep_r, sweep_nxt;
  logic [IDX_W-1:0]    waddr_r;
  logic                pend_r, pend_nxt;
  out_rsp_t            out_r;
  logic                out_valid_r, out_valid_nxt;

  logic [COL_W:0]      col_ext, col_tmp;
  logic                is_write, is_print, adv, last_row, read_hit;
  logic [IDX_W-1:0]    cur_pos, sweep_src;
  logic [CELL_W-1:0]   print_word, blank_word;
  logic                mem_we, mem_re;
  logic [IDX_W-1:0]    mem_waddr, mem_raddr;
  logic [CELL_W-1:0]   mem_wdata;

  assign print_word = {bg_r, fg_r, item_r.char_code};
  assign blank_word = {bg_r, fg_r, CH_SPACE};
  assign is_write   = item_r.operation == OP_WRITE;
  assign is_print   = item_r.char_code >= CH_SPACE && item_r.char_code <= CH_LAST;
  assign last_row   = row_r == ROW_W'(ROWS - 1);
  assign read_hit   = item_r.operation == OP_READ && item_r.cell_index < IDX_W'(CELLS);
  assign cur_pos    = IDX_W'(row_r) * IDX_W'(COLS) + IDX_W'(col_r);
  assign sweep_src  = sweep_r + IDX_W'(COLS);
  assign col_ext    = {1'b0, col_r};

  // column after the character rule, one bit wider to see the wrap
  always_comb begin
    col_tmp = col_ext;
    if (is_write) begin
      if (item_r.char_code == CH_BS) begin
        col_tmp = (col_r != '0) ? col_ext - 1'b1 : col_ext;
      end else if (item_r.char_code == CH_TAB) begin
        col_tmp = (col_ext & ~(COL_W+1)'(TAB_STOP - 1)) + (COL_W+1)'(TAB_STOP);
      end else if (item_r.char_code == CH_CR) begin
        col_tmp = '0;
      end else if (is_print) begin
        col_tmp = col_ext + 1'b1;
      end
    end
  end

  assign adv = (is_write && (item_r.char_code == CH_LF || col_tmp >= (COL_W+1)'(COLS)))
            || (item_r.operation == OP_LINE && col_r != '0);

  assign sts.is_clear  = item_r.operation == OP_CLEAR;
  assign sts.scroll    = adv && last_row;
  assign sts.copy_done = sweep_r == IDX_W'(SCROLL_CELLS);
  assign sts.fill_last = sweep_r == IDX_W'(CELLS - 1);
  assign sts.out_busy  = out_valid_r;

  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    sweep_nxt     = sweep_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.exec) begin
      sweep_nxt = '0;
      pend_nxt  = 1'b0;
      if (sts.is_clear) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (adv) begin
        col_nxt = '0;
        row_nxt = last_row ? row_r : row_r + 1'b1;
      end else begin
        col_nxt = col_tmp[COL_W-1:0];
      end
    end
    if (cmd.scroll_step) begin
      pend_nxt = !sts.copy_done;
      if (!sts.copy_done) begin
        sweep_nxt = sweep_r + 1'b1;
      end
    end
    if (cmd.fill_step) begin
      sweep_nxt = sweep_r + 1'b1;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  // one write and one read port on the screen store
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_r;
    mem_wdata = blank_word;
    mem_re    = 1'b0;
    mem_raddr = sweep_src;
    if (cmd.exec && is_write && is_print) begin
      mem_we    = 1'b1;
      mem_waddr = cur_pos;
      mem_wdata = print_word;
    end
    if (cmd.scroll_step && pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = waddr_r;
      mem_wdata = mem_q;
    end
    if (cmd.fill_step) begin
      mem_we = 1'b1;
    end
    if (cmd.exec && read_hit) begin
      mem_re    = 1'b1;
      mem_raddr = item_r.cell_index;
    end
    if (cmd.scroll_step && !sts.copy_done) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.scroll_step) begin
      waddr_r <= sweep_r;
    end
    if (cmd.load_out) begin
      out_r.cursor_row   <= row_r;
      out_r.cursor_col   <= col_r;
      out_r.cursor_index <= cur_pos;
      out_r.read_cell    <= read_hit ? mem_q : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      sweep_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      fg_r        <= FG_RESET;
      bg_r        <= BG_RESET;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      sweep_r     <= sweep_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FG:  fg_r <= cfg_wdata;
          CFG_BG:  bg_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  `TCW_ASSERT(a_col_range, (col_r < COL_W'(COLS)), "cursor column beyond last column")
  `TCW_ASSERT(a_row_range, (row_r < ROW_W'(ROWS)), "cursor row beyond last row")
  `TCW_ASSERT(a_read_zero, ((cmd.load_out && item_r.operation != OP_READ) |=> (out_r.read_cell == '0)), "cell word not zero on non-read result")

endmodule

FILE: rtl/core/tcw_ctrl.sv
// controller of the text console writer: sequences execute, scroll copy, fill and result
// depends on tcw_pkg and the assertion macro header
`include "text_console_writer_assert.svh"

module tcw_ctrl import tcw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_ready,
  input  tcw_sts_t sts,
  output tcw_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_SCROLL = 5'b00100,
    S_BLANK  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_clear) begin
          state_nxt = S_BLANK;
        end else if (sts.scroll) begin
          state_nxt = S_SCROLL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCROLL: begin
        // copy each row up, then blank the bottom row
        cmd.scroll_step = 1'b1;
        if (sts.copy_done) begin
          state_nxt = S_BLANK;
        end
      end
      S_BLANK: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `TCW_ASSERT(a_cmd_excl, ($onehot0(cmd)), "more than one datapath command at once")
  `TCW_ASSERT(a_accept_exec, ((in_valid && in_ready) |=> (state_r == S_EXEC)), "accepted request not executed")
  `TCW_IMPLY(a_scroll_exit, (state_r == S_SCROLL && state_nxt != S_SCROLL), (state_nxt == S_BLANK), "scroll left without blanking bottom row")

endmodule

FILE: verif/tb_text_console_writer.sv
// testbench for the text console writer: requests go in over valid/ready, cursor reports
// come back and are compared with an in-bench model of the screen store and cursor
// depends on tcw_pkg for the request/result structs, geometry and operation codes
module tb_text_console_writer import tcw_pkg::*;;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_req_t              in_data;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_rsp_t             out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COLOR_W-1:0]   cfg_wdata;

  text_console_writer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // console model state
  logic [CELL_W-1:0]  screen_mem [CELLS];
  logic [ROW_W-1:0]   cur_row;
  logic [COL_W-1:0]   cur_col;
  logic [COLOR_W-1:0] colour_fg;
  logic [COLOR_W-1:0] colour_bg;
  bit                 screen_known;

  out_rsp_t cursor_report_q [$];
  int       err_count;
  bit       gaps_on;

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic void next_line();
    cur_col = '0;
    cur_row = cur_row + 1'b1;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < SCROLL_CELLS; i++)
        screen_mem[i] = screen_mem[i + COLS];
      for (int i = 0; i < COLS; i++)
        screen_mem[SCROLL_CELLS + i] = {colour_bg, colour_fg, CH_SPACE};
      cur_row = ROW_W'(ROWS - 1);
    end
  endfunction

  function automatic void type_char(logic [CHAR_W-1:0] code);
    if (code == CH_BS) begin
      if (cur_col != 0)
        cur_col = cur_col - 1'b1;
    end else if (code == CH_TAB) begin
      cur_col = COL_W'(int'(cur_col) + TAB_STOP - (int'(cur_col) % TAB_STOP));
    end else if (code == CH_CR) begin
      cur_col = '0;
    end else if (code == CH_LF) begin
      next_line();
    end else if (code >= CH_SPACE && code <= CH_LAST) begin
      screen_mem[int'(cur_row) * COLS + int'(cur_col)] = {colour_bg, colour_fg, code};
      cur_col = cur_col + 1'b1;
    end
    if (cur_col >= COLS)
      next_line();
  endfunction

  function automatic out_rsp_t predict_console(in_req_t req);
    out_rsp_t          rsp;
    logic [CELL_W-1:0] cell_word;
    cell_word = '0;
    case (req.operation)
      OP_WRITE: type_char(req.char_code);
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++)
          screen_mem[i] = {colour_bg, colour_fg, CH_SPACE};
        cur_row = '0;
        cur_col = '0;
        screen_known = 1'b1;
      end
      OP_LINE: begin
        if (cur_col != 0)
          next_line();
      end
      default: begin
        if (req.cell_index < CELLS)
          cell_word = screen_mem[req.cell_index];
      end
    endcase
    rsp.cursor_row   = cur_row;
    rsp.cursor_col   = cur_col;
    rsp.cursor_index = IDX_W'(int'(cur_row) * COLS + int'(cur_col));
    rsp.read_cell    = cell_word;
    return rsp;
  endfunction

  function automatic in_req_t make_req(logic [OP_W-1:0] op, logic [CHAR_W-1:0] code,
                                       logic [IDX_W-1:0] idx);
    in_req_t req;
    req.operation  = op;
    req.char_code  = code;
    req.cell_index = idx;
    return req;
  endfunction

  // mostly lines of printable text with line breaks and reads, plus stray bytes
  function automatic in_req_t next_text_req();
    in_req_t     req;
    int unsigned pick;
    req = make_req(OP_WRITE, CHAR_W'($urandom_range(255)), IDX_W'($urandom_range(2047)));
    pick = $urandom_range(999);
    if (pick < 560) begin
      req.char_code = CHAR_W'($urandom_range(int'(CH_LAST), int'(CH_SPACE)));
    end else if (pick < 640) begin
      case (pick % 4)
        0:       req.char_code = CH_BS;
        1:       req.char_code = CH_TAB;
        2:       req.char_code = CH_CR;
        default: req.char_code = CH_LF;
      endcase
    end else if (pick < 690) begin
      // any byte, mostly control or high codes that are ignored
    end else if (pick < 790) begin
      req.operation = OP_LINE;
    end else if (pick < 795) begin
      req.operation = OP_CLEAR;
    end else begin
      req.operation = OP_READ;
      if (screen_known && $urandom_range(9) != 0)
        req.cell_index = IDX_W'($urandom_range(CELLS - 1));
      else
        req.cell_index = IDX_W'($urandom_range(2047, CELLS));
    end
    return req;
  endfunction

  task automatic send_req(in_req_t req);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 23) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = req;
    do @(posedge clk); while (!in_ready);
    cursor_report_q.push_back(predict_console(req));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (cursor_report_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_colours(logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_index = CFG_FG;
    cfg_wdata = fg;
    @(negedge clk);
    cfg_index = CFG_BG;
    cfg_wdata = bg;
    @(negedge clk);
    cfg_we    = 1'b0;
    colour_fg = fg;
    colour_bg = bg;
  endtask

  task automatic run_text(int n_items);
    repeat (n_items) begin
      if ($urandom_range(99) < 2)
        wait_drained();
      send_req(next_text_req());
    end
  endtask

  // reset colours; the store is not read in range until the first clear
  task automatic test_directed_ops();
    send_req(make_req(OP_WRITE, CH_BS, 11'd0));
    send_req(make_req(OP_WRITE, 8'h00, 11'd2047));
    send_req(make_req(OP_WRITE, 8'hFF, 11'd0));
    send_req(make_req(OP_WRITE, 8'h80, 11'd0));
    send_req(make_req(OP_WRITE, 8'h1F, 11'd0));
    send_req(make_req(OP_READ, 8'hFF, 11'd2000));
    send_req(make_req(OP_READ, 8'h00, 11'd2047));
    send_req(make_req(OP_LINE, 8'h41, 11'd5));
    send_req(make_req(OP_CLEAR, 8'h00, 11'd0));
    send_req(make_req(OP_WRITE, CH_SPACE, 11'd0));
    send_req(make_req(OP_WRITE, CH_LAST, 11'd0));
    send_req(make_req(OP_WRITE, CH_BS, 11'd0));
    send_req(make_req(OP_WRITE, CH_TAB, 11'd0));
    send_req(make_req(OP_WRITE, CH_CR, 11'd0));
    send_req(make_req(OP_WRITE, 8'h48, 11'd0));
    send_req(make_req(OP_LINE, 8'h00, 11'd0));
    send_req(make_req(OP_WRITE, CH_LF, 11'd0));
    send_req(make_req(OP_READ, 8'h00, 11'd0));
    send_req(make_req(OP_READ, 8'h00, 11'd1));
    send_req(make_req(OP_READ, 8'h00, 11'd1999));
    // tab stops from column 0 up to the edge, then wrap onto the next line
    repeat (10) send_req(make_req(OP_WRITE, CH_TAB, 11'd0));
  endtask

  task automatic test_dark_on_light();
    set_colours(4'h0, 4'hF);
    gaps_on = 1'b1;
    run_text(190);
  endtask

  task automatic test_burst_no_gaps();
    set_colours(4'hF, 4'hF);
    gaps_on = 1'b0;
    run_text(170);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_colours();
    repeat (3) begin
      set_colours(COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)));
      run_text(130);
    end
    set_colours(4'h0, 4'h0);
    run_text(30);
  endtask

  // receiver back-pressure
  always @(negedge clk)
    out_ready <= gaps_on ? ($urandom_range(99) >= 23) : 1'b1;

  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (cursor_report_q.size() == 0) begin
        report_error($sformatf("result with no request pending: %h", out_data));
      end else begin
        want = cursor_report_q.pop_front();
        if (out_data.cursor_row !== want.cursor_row)
          report_error($sformatf("cursor_row got %0d expected %0d",
                                 out_data.cursor_row, want.cursor_row));
        if (out_data.cursor_col !== want.cursor_col)
          report_error($sformatf("cursor_col got %0d expected %0d",
                                 out_data.cursor_col, want.cursor_col));
        if (out_data.cursor_index !== want.cursor_index)
          report_error($sformatf("cursor_index got %0d expected %0d",
                                 out_data.cursor_index, want.cursor_index));
        if (out_data.read_cell !== want.read_cell)
          report_error($sformatf("read_cell got %h expected %h",
                                 out_data.read_cell, want.read_cell));
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_FG;
    cfg_wdata    = '0;
    cur_row      = '0;
    cur_col      = '0;
    colour_fg    = FG_RESET;
    colour_bg    = BG_RESET;
    screen_known = 1'b0;
    err_count    = 0;
    gaps_on      = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_ops();
    test_dark_on_light();
    test_burst_no_gaps();
    test_random_colours();

    wait_drained();
    repeat (16) @(negedge clk);
    if (err_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // allows for every request being a full-screen sweep under heavy stalls
  initial begin
    #80000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
